[rtl/tmr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_pkg
// Types, constants and control structs shared by the Turing machine runner.
// ----------------------------------------------------------------------------
package tmr_pkg;

    // Tape depth must be a power of two: clear sweep addresses wrap by truncation.
    localparam int TAPE_DEPTH = 262144;
    localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
    localparam int TAPE_MID   = TAPE_DEPTH / 2;
    localparam int CNT_W      = $clog2(TAPE_DEPTH + 1);

    localparam int STEP_W     = 17;
    localparam int RULE_W     = 5;
    localparam int OUTC_W     = 2;
    // head excursion is bounded by the step count, so one sign bit more suffices
    localparam int OFF_W      = STEP_W + 1;

    localparam logic [STEP_W-1:0] STEP_LIMIT_RST = STEP_W'(100000);

    localparam logic [OUTC_W-1:0] OUT_HALT  = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_LIMIT = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_UNDEF = 2'd2;

    localparam logic [2:0] ST_HALT = 3'd7;

    typedef logic [TAPE_AW-1:0] tape_addr_t;
    typedef logic [CNT_W-1:0]   clr_cnt_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [RULE_W-1:0]  rule_t;

    typedef struct packed {
        rule_t rule_a0;
        rule_t rule_a1;
        rule_t rule_b0;
        rule_t rule_b1;
        rule_t rule_c0;
        rule_t rule_c1;
        rule_t rule_d0;
        rule_t rule_d1;
    } tmr_in_t;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        step_t             last_step_a;
        step_t             last_step_b;
        step_t             last_step_c;
        step_t             last_step_d;
    } tmr_out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENTER,
        S_EXEC,
        S_DONE
    } tmr_state_t;

    typedef struct packed {
        logic start;     // load program, reset run state
        logic enter;     // count step, record entry, tape read issued
        logic exec;      // apply rule: write, move, next state
        logic load_out;  // capture result word
        logic clr_init;  // set up sweep over touched region
        logic clr_step;  // clear one tape cell
    } tmr_cmd_t;

    typedef struct packed {
        logic over;      // step count would exceed the limit
        logic stop;      // rule leads to halt or an undefined state
        logic clr_last;  // last cell of the sweep
    } tmr_stat_t;

endpackage

[rtl/tmr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_ctrl
// Run sequencer: accept, alternate enter/execute steps, deliver, clear tape.
// ----------------------------------------------------------------------------
module tmr_ctrl
    import tmr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output tmr_cmd_t  cmd,
    input  tmr_stat_t stat
);

    tmr_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;   // power-up sweep of the whole tape
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_ENTER;
                end
            end
            S_ENTER: begin
                cmd.enter  = 1'b1;
                state_next = stat.over ? S_DONE : S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.stop ? S_DONE : S_ENTER;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.clr_init = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_CLEAR;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten while pending");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside completion");

    a_enter_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ENTER && !stat.over) |=> state_reg == S_EXEC)
        else $error("step entry not followed by execute");

    a_stop_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && stat.stop) |=> state_reg == S_DONE)
        else $error("halt or undefined state did not end the run");

endmodule

[rtl/tmr_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_datapath
// Tape memory, head, step counter, entry records, result word, clear sweep.
// ----------------------------------------------------------------------------
module tmr_datapath
    import tmr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  tmr_cmd_t  cmd,
    output tmr_stat_t stat,
    input  tmr_in_t   s_data,
    input  logic      cfg_valid,
    input  step_t     cfg_data,
    output tmr_out_t  m_data
);

    logic tape_mem [TAPE_DEPTH];
    logic rd_reg;

    step_t             limit_reg;
    rule_t             rules_reg [8];
    tape_addr_t        head_reg, head_next;
    step_t             step_reg;
    logic [STEP_W:0]   step_inc;
    logic [1:0]        mstate_reg;
    step_t             last_reg [4];
    logic [OUTC_W-1:0] outcome_reg;
    logic signed [OFF_W-1:0] off_reg, off_next, min_reg, max_reg;
    logic [OFF_W:0]    span;
    tape_addr_t        clr_addr_reg;
    clr_cnt_t          clr_cnt_reg;
    tmr_out_t          out_reg;
    rule_t             rule;
    logic              we;
    tape_addr_t        wa;
    logic              wd;

    // ---- config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= STEP_LIMIT_RST;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // ---- step logic
    assign step_inc = {1'b0, step_reg} + 1'b1;
    assign rule     = rules_reg[{mstate_reg, rd_reg}];

    always_comb begin
        if (rule[3]) begin
            head_next = (head_reg == tape_addr_t'(TAPE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            off_next  = off_reg + OFF_W'(1);
        end else begin
            head_next = (head_reg == '0) ? tape_addr_t'(TAPE_DEPTH - 1) : head_reg - 1'b1;
            off_next  = off_reg - OFF_W'(1);
        end
    end

    assign stat.over = step_inc > {1'b0, limit_reg};
    assign stat.stop = rule[2];
    assign stat.clr_last = (clr_cnt_reg == clr_cnt_t'(1));

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rules_reg[0] <= s_data.rule_a0;
            rules_reg[1] <= s_data.rule_a1;
            rules_reg[2] <= s_data.rule_b0;
            rules_reg[3] <= s_data.rule_b1;
            rules_reg[4] <= s_data.rule_c0;
            rules_reg[5] <= s_data.rule_c1;
            rules_reg[6] <= s_data.rule_d0;
            rules_reg[7] <= s_data.rule_d1;
            head_reg     <= tape_addr_t'(TAPE_MID);
            step_reg     <= '0;
            mstate_reg   <= '0;
            off_reg      <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            for (int i = 0; i < 4; i++) begin
                last_reg[i] <= '0;
            end
        end
        if (cmd.enter) begin
            if (stat.over) begin
                outcome_reg <= OUT_LIMIT;
            end else begin
                step_reg             <= step_inc[STEP_W-1:0];
                last_reg[mstate_reg] <= step_inc[STEP_W-1:0];
            end
        end
        if (cmd.exec) begin
            head_reg   <= head_next;
            off_reg    <= off_next;
            mstate_reg <= rule[1:0];
            if (off_next < min_reg) begin
                min_reg <= off_next;
            end
            if (off_next > max_reg) begin
                max_reg <= off_next;
            end
            if (rule[2:0] == ST_HALT) begin
                outcome_reg <= OUT_HALT;
            end else if (rule[2]) begin
                outcome_reg <= OUT_UNDEF;
            end
        end
        if (cmd.load_out) begin
            out_reg.outcome     <= outcome_reg;
            out_reg.last_step_a <= last_reg[0];
            out_reg.last_step_b <= last_reg[1];
            out_reg.last_step_c <= last_reg[2];
            out_reg.last_step_d <= last_reg[3];
        end
    end

    // ---- clear sweep over the touched span (whole tape after reset)
    assign span = (OFF_W+1)'(max_reg) - (OFF_W+1)'(min_reg) + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_cnt_reg  <= clr_cnt_t'(TAPE_DEPTH);
        end else if (cmd.clr_init) begin
            clr_addr_reg <= tape_addr_t'(TAPE_MID) + tape_addr_t'(min_reg);
            if (32'(span) > 32'(TAPE_DEPTH)) begin
                clr_cnt_reg <= clr_cnt_t'(TAPE_DEPTH);
            end else begin
                clr_cnt_reg <= clr_cnt_t'(span);
            end
        end else if (cmd.clr_step) begin
            clr_addr_reg <= (clr_addr_reg == tape_addr_t'(TAPE_DEPTH - 1)) ?
                            '0 : clr_addr_reg + 1'b1;
            clr_cnt_reg  <= clr_cnt_reg - 1'b1;
        end
    end

    // ---- tape memory: one write port, one registered read at the head
    assign we = cmd.exec || cmd.clr_step;
    assign wa = cmd.exec ? head_reg : clr_addr_reg;
    assign wd = cmd.exec ? rule[4] : 1'b0;

    always_ff @(posedge aclk) begin
        if (we) begin
            tape_mem[wa] <= wd;
        end
        rd_reg <= tape_mem[head_reg];
    end

    assign m_data = out_reg;

endmodule

[rtl/turing_machine_runner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turing_machine_runner
// Runs one 4-state, 2-symbol Turing machine program per input word.
// ----------------------------------------------------------------------------
// Each input word is a program of eight rules; the run starts on a blank
// tape with the head at its middle in state A. Each step is an enter state
// that reads the tape cell at the head into a register, then an execute
// state that applies the rule. After the result word is loaded, the cells
// the head visited are swept back to zero, one per cycle, before the next
// word is taken. After reset, the whole tape (262144 cells) is cleared, one
// cell a cycle, before the first word is accepted. The step_limit register
// is always writable; change it only while no run is in progress.
// ----------------------------------------------------------------------------
module turing_machine_runner
    import tmr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tmr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tmr_out_t m_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  step_t    cfg_data
);

    tmr_cmd_t  cmd;
    tmr_stat_t stat;

    assign cfg_ready = 1'b1;

    tmr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    tmr_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

endmodule

[tb/sv/tb_turing_machine_runner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turing_machine_runner
// Self-checking bench for the 4-state, 2-symbol Turing machine runner.
// ----------------------------------------------------------------------------
// Programs are queued by the stimulus process and presented by a clocked
// driver; every accepted program is run on a behavioral tape right away and
// the result word it should produce is queued. A clocked monitor takes the
// result words with random back-pressure and compares them field by field.
// The step limit is changed between phases, only once the runner is drained:
// reset value, zero, one, the maximum, then several small random settings.
// ----------------------------------------------------------------------------
module tb_turing_machine_runner;
    import tmr_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 1500000;
    localparam int HOLD_AFTER     = 50;     // results taken before the long back-pressure
    localparam int LONG_HOLD      = 3000;
    localparam int TAIL_CYCLES    = 200;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_WORDS    = 25;

    localparam step_t STEP_MAX = '1;

    localparam logic [2:0] ST_A = 3'd0;
    localparam logic [2:0] ST_B = 3'd1;
    localparam logic [2:0] ST_C = 3'd2;
    localparam logic [2:0] ST_D = 3'd3;

    localparam logic MOVE_L = 1'b0;
    localparam logic MOVE_R = 1'b1;

    typedef struct packed {
        logic       wr;
        logic       right;
        logic [2:0] dest;
    } rule_bits_t;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    tmr_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    tmr_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    step_t    cfg_data  = '0;

    tmr_in_t  program_q [$];
    tmr_out_t result_q  [$];

    step_t limit_setting = STEP_LIMIT_RST;
    bit    tape_image [TAPE_DEPTH];

    int items_queued   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int tx_gap         = 0;
    int tx_calm        = 0;
    int rx_stall       = 0;
    int rx_calm        = 0;

    turing_machine_runner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Behavioral machine
    // ------------------------------------------------------------------------
    function automatic tmr_out_t run_program(tmr_in_t prog, step_t limit);
        rule_t [0:7] rules;
        rule_bits_t  r;
        tmr_out_t    res;
        logic [2:0]  cur;
        int unsigned head;
        int          steps;
        int          base;
        bit          done;
        bit          sym;
        rules = prog;
        res   = '0;
        head  = TAPE_MID;
        cur   = ST_A;
        steps = 0;
        done  = 1'b0;
        while (!done) begin
            steps++;
            if (steps > limit) begin
                res.outcome = OUT_LIMIT;
                done = 1'b1;
            end else begin
                case (cur)
                    ST_A:    res.last_step_a = step_t'(steps);
                    ST_B:    res.last_step_b = step_t'(steps);
                    ST_C:    res.last_step_c = step_t'(steps);
                    default: res.last_step_d = step_t'(steps);
                endcase
                sym = tape_image[head];
                r = rules[{cur[1:0], sym}];
                tape_image[head] = r.wr;
                if (r.right == MOVE_R) begin
                    head = (head + 1 == TAPE_DEPTH) ? 0 : head + 1;
                end else begin
                    head = (head == 0) ? TAPE_DEPTH - 1 : head - 1;
                end
                cur = r.dest;
                if (cur == ST_HALT) begin
                    res.outcome = OUT_HALT;
                    done = 1'b1;
                end else if (cur > ST_D) begin
                    res.outcome = OUT_UNDEF;
                    done = 1'b1;
                end
            end
        end
        // head never strays more than steps cells from the middle
        base = ((TAPE_MID - steps - 1) % TAPE_DEPTH + TAPE_DEPTH) % TAPE_DEPTH;
        for (int k = 0; k <= 2 * steps + 2 && k < TAPE_DEPTH; k++) begin
            tape_image[(base + k) % TAPE_DEPTH] = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Program construction
    // ------------------------------------------------------------------------
    function automatic rule_t rule_of(logic wr, logic right, logic [2:0] dest);
        rule_bits_t r;
        r.wr    = wr;
        r.right = right;
        r.dest  = dest;
        return r;
    endfunction

    function automatic logic [2:0] random_dest();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) return 3'($urandom_range(ST_A, ST_D));
        if (pick < 93) return ST_HALT;
        return 3'($urandom_range(ST_D + 1, ST_HALT - 1));
    endfunction

    function automatic rule_t random_rule();
        return rule_of(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), random_dest());
    endfunction

    // mostly programs that stay inside A-D for a while; some pure noise
    function automatic tmr_in_t random_program();
        rule_t [0:7] rules;
        logic [63:0] noise;
        if ($urandom_range(0, 4) == 0) begin
            noise = {$urandom, $urandom};
            return noise[$bits(tmr_in_t)-1:0];
        end
        for (int i = 0; i < 8; i++) rules[i] = random_rule();
        return rules;
    endfunction

    // four-state busy beaver champion, halts after 107 steps
    function automatic tmr_in_t busy_beaver();
        rule_t [0:7] rules;
        rules[0] = rule_of(1'b1, MOVE_R, ST_B);
        rules[1] = rule_of(1'b1, MOVE_L, ST_B);
        rules[2] = rule_of(1'b1, MOVE_L, ST_A);
        rules[3] = rule_of(1'b0, MOVE_L, ST_C);
        rules[4] = rule_of(1'b1, MOVE_R, ST_HALT);
        rules[5] = rule_of(1'b1, MOVE_L, ST_D);
        rules[6] = rule_of(1'b1, MOVE_R, ST_D);
        rules[7] = rule_of(1'b0, MOVE_R, ST_A);
        return rules;
    endfunction

    // A -> B -> C -> D -> halt on a blank tape
    function automatic tmr_in_t state_chain();
        tmr_in_t prog;
        prog = random_program();
        prog.rule_a0 = rule_of(1'b0, MOVE_R, ST_B);
        prog.rule_b0 = rule_of(1'b0, MOVE_R, ST_C);
        prog.rule_c0 = rule_of(1'b0, MOVE_R, ST_D);
        prog.rule_d0 = rule_of(1'b1, MOVE_L, ST_HALT);
        return prog;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    task automatic queue_program(tmr_in_t prog);
        program_q.push_back(prog);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || result_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_step_limit(step_t value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_setting = value;
    endtask

    task automatic check_field(string name, step_t want, step_t got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Program driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                result_q.push_back(run_program(s_data, limit_setting));
                items_accepted++;
                next_valid = 1'b0;
                if (tx_calm > 0) begin
                    tx_calm--;
                    tx_gap = 0;
                end else begin
                    tx_gap = pick_gap();
                    if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(10, 30);
                end
            end
            if (!next_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (program_q.size() != 0) begin
                    next_valid = 1'b1;
                    s_data <= program_q.pop_front();
                end
            end
            s_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : collect
        tmr_out_t want;
        logic     next_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    $error("result word with no program pending");
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("outcome", step_t'(want.outcome), step_t'(m_data.outcome));
                    check_field("last_step_a", want.last_step_a, m_data.last_step_a);
                    check_field("last_step_b", want.last_step_b, m_data.last_step_b);
                    check_field("last_step_c", want.last_step_c, m_data.last_step_c);
                    check_field("last_step_d", want.last_step_d, m_data.last_step_d);
                end
                // long back-pressure so the runner backs up into its input
                if (results_seen == HOLD_AFTER) rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                next_ready = 1'b0;
            end else if (rx_calm > 0) begin
                rx_calm--;
                next_ready = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        rx_stall = pick_gap();
                        next_ready = (rx_stall == 0);
                        if (rx_stall > 0) rx_stall--;
                    end
                    1: begin
                        rx_calm = $urandom_range(50, 400);
                        next_ready = 1'b1;
                    end
                    default: next_ready = 1'b1;
                endcase
            end
            m_ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no word moved on any channel for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_turing_machine_runner failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        tmr_in_t prog;
        int      lo [RANDOM_PHASES];
        int      hi [RANDOM_PHASES];
        lo = '{1, 1, 1, 200};
        hi = '{40, 250, 16, 600};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // step limit at its reset value: programs that stop early
        queue_program('1);
        queue_program(busy_beaver());
        for (int code = ST_D + 1; code < ST_HALT; code++) begin
            prog = random_program();
            prog.rule_a0 = rule_of(1'b1, 1'(code), 3'(code));
            queue_program(prog);
        end
        queue_program(state_chain());
        wait_drained();

        // zero limit: the very first entry is already over
        write_step_limit('0);
        queue_program('0);
        queue_program(busy_beaver());
        wait_drained();

        write_step_limit(step_t'(1));
        queue_program('0);
        queue_program(busy_beaver());
        queue_program(state_chain());
        wait_drained();

        // largest limit: one program that never stops, one that halts
        write_step_limit(STEP_MAX);
        prog = random_program();
        prog.rule_a0 = rule_of(1'b1, MOVE_R, ST_A);
        prog.rule_a1 = rule_of(1'b1, MOVE_R, ST_A);
        queue_program(prog);
        queue_program(busy_beaver());
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_step_limit(step_t'($urandom_range(lo[ph], hi[ph])));
            repeat (PHASE_WORDS) queue_program(random_program());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_turing_machine_runner passed");
        end else begin
            $display("tb_turing_machine_runner failed");
        end
        $finish;
    end

endmodule
